[hw/rtl/scd_pkg.sv]
package scd_pkg;

	localparam int MAX_PENDING_DEF  = 32;
	localparam int NUM_CHANNELS_DEF = 16;
	localparam int ID_BITS_DEF      = 8;

	localparam int SENDER_W = 8;
	localparam int CHAN_W   = 4;
	localparam int CHAN_CNT = 1 << CHAN_W;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OCW       = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_ENQ,
		CMD_DROP,
		CMD_TICK
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_SUCCESS   = 2'd0,
		ST_COLLISION = 2'd1,
		ST_DROPPED   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_REPLAY,
		BK_FLUSH
	} back_state_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [SENDER_W-1:0]   sender;
		logic [CHAN_W-1:0]     chan;
	} cmd_t;

	typedef struct packed {
		logic [SENDER_W-1:0]   sender;
		logic [CHAN_W-1:0]     chan;
		status_t               status;
		logic                  last;
	} res_t;

endpackage

[hw/rtl/slotted_channel_collision_detect_core.sv]
// Requests produce no item; a dropped-request item reaches the result ports via both queues.
// A tick with N queued requests passes the command queue, rd_data_s1 and the output queue,
// then gives one item per cycle while pop keeps up; the replay unit works through REPLAY and FLUSH.
// Requests and ticks are accepted one per cycle until the 4-entry command queue fills.
// Reset clears the queue count, channel use counts, both queues and the replay control;
// the request store itself holds stale data until written.
module slotted_channel_collision_detect_core #(
	parameter int MAX_PENDING  = scd_pkg::MAX_PENDING_DEF,
	parameter int NUM_CHANNELS = scd_pkg::NUM_CHANNELS_DEF,
	parameter int ID_BITS      = scd_pkg::ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          req_type,
	input  logic [scd_pkg::SENDER_W-1:0]  sender_id,
	input  logic [scd_pkg::CHAN_W-1:0]    channel,
	output logic                          empty,
	input  logic                          pop,
	output logic [scd_pkg::SENDER_W-1:0]  sender_id_out,
	output logic [scd_pkg::CHAN_W-1:0]    channel_out,
	output logic [1:0]                    status,
	output logic                          last
);
	import scd_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);
	localparam int CQW   = $clog2(CMD_DEPTH + 1);

	cmd_t                 fe_cmd;
	logic                 fe_push;
	logic                 cmd_full;
	logic                 cmd_empty;
	logic [CMD_W-1:0]     cmd_head;
	logic [CQW-1:0]       cmd_count;
	logic                 cmd_pop;
	logic                 res_push;
	res_t                 be_res;
	logic [RES_W-1:0]     res_head;
	res_t                 out_res;
	logic                 out_full;
	logic [OCW-1:0]       out_count;

	scd_front #(
		.MAX_PENDING (MAX_PENDING),
		.ID_BITS     (ID_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.req_type  (req_type),
		.sender_id (sender_id),
		.channel   (channel),
		.cmd_full  (cmd_full),
		.cmd_push  (fe_push),
		.cmd       (fe_cmd)
	);

	scd_fifo #(
		.DEPTH (CMD_DEPTH),
		.WIDTH (CMD_W)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fe_push),
		.wr_data (fe_cmd),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.full    (cmd_full),
		.empty   (cmd_empty),
		.count   (cmd_count)
	);

	scd_back #(
		.MAX_PENDING  (MAX_PENDING),
		.NUM_CHANNELS (NUM_CHANNELS),
		.ID_BITS      (ID_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (~cmd_empty),
		.cmd       (cmd_t'(cmd_head)),
		.cmd_pop   (cmd_pop),
		.out_count (out_count),
		.res_push  (res_push),
		.res       (be_res)
	);

	scd_fifo #(
		.DEPTH (OUT_DEPTH),
		.WIDTH (RES_W)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (be_res),
		.rd_en   (pop),
		.rd_data (res_head),
		.full    (out_full),
		.empty   (empty),
		.count   (out_count)
	);

	assign full          = cmd_full;
	assign out_res       = res_t'(res_head);
	assign sender_id_out = out_res.sender;
	assign channel_out   = out_res.chan;
	assign status        = out_res.status;
	assign last          = out_res.last;

	// the replay credit check must never let a result hit a full output queue
	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !out_full)
		else $error("result pushed into full output queue");

	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command popped from empty queue");

	a_last_not_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (status == ST_SUCCESS || status == ST_COLLISION))
		else $error("last marked on a dropped item");

	a_cmd_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_full |-> (cmd_count == CQW'(CMD_DEPTH)))
		else $error("command queue full flag inconsistent with count");

endmodule

[hw/rtl/scd_fifo.sv]
module scd_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [WIDTH-1:0]             wr_data,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[hw/rtl/scd_front.sv]
module scd_front #(
	parameter int MAX_PENDING = 32,
	parameter int ID_BITS     = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          req_type,
	input  logic [scd_pkg::SENDER_W-1:0]  sender_id,
	input  logic [scd_pkg::CHAN_W-1:0]    channel,
	input  logic                          cmd_full,
	output logic                          cmd_push,
	output scd_pkg::cmd_t                 cmd
);
	import scd_pkg::*;

	localparam int CW  = $clog2(MAX_PENDING + 1);
	localparam int IdW = (ID_BITS < SENDER_W) ? ID_BITS : SENDER_W;
	localparam logic [SENDER_W-1:0] IdMask = SENDER_W'((64'd1 << IdW) - 64'd1);

	// requests queued in the current period, as the back end will see them
	logic [CW-1:0] cnt_q;

	assign cmd_push = push & ~cmd_full;

	always_comb begin
		cmd.sender = sender_id & IdMask;
		cmd.chan   = channel;
		if (req_type) begin
			cmd.kind = CMD_TICK;
		end else if (cnt_q == CW'(MAX_PENDING)) begin
			cmd.kind = CMD_DROP;
		end else begin
			cmd.kind = CMD_ENQ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd_push) begin
			unique case (cmd.kind)
				CMD_TICK: cnt_q <= '0;
				CMD_ENQ:  cnt_q <= cnt_q + CW'(1);
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/scd_back.sv]
module scd_back #(
	parameter int MAX_PENDING  = 32,
	parameter int NUM_CHANNELS = 16,
	parameter int ID_BITS      = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  scd_pkg::cmd_t                cmd,
	output logic                         cmd_pop,
	input  logic [scd_pkg::OCW-1:0]      out_count,
	output logic                         res_push,
	output scd_pkg::res_t                res
);
	import scd_pkg::*;

	localparam int AW    = $clog2(MAX_PENDING);
	localparam int CW    = $clog2(MAX_PENDING + 1);
	localparam int SID_W = (ID_BITS < SENDER_W) ? ID_BITS : SENDER_W;
	localparam int EW    = SID_W + CHAN_W;
	// only channel codes 0..15 arrive, so at most 16 slots are ever touched
	localparam int NSLOT = (NUM_CHANNELS < CHAN_CNT) ? NUM_CHANNELS : CHAN_CNT;
	localparam int SW    = $clog2(NSLOT);

	back_state_t      state_q, state_d;
	logic [EW-1:0]    mem_q [MAX_PENDING];
	logic [CW-1:0]    wr_cnt_q;
	logic [AW-1:0]    rd_idx_q;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic [EW-1:0]    rd_data_s1;
	logic [1:0]       use_cnt_q [NSLOT];
	logic [SW-1:0]    slot_lut [CHAN_CNT];

	logic             room;
	logic             rd_last_next;
	logic             do_enq;
	logic             do_drop;
	logic             issue;
	logic             clear;
	logic [SW-1:0]    enq_slot;
	logic [SW-1:0]    rd_slot;
	logic [CHAN_W-1:0] rd_chan;
	logic [SID_W-1:0] rd_sender;

	for (genvar i = 0; i < CHAN_CNT; i++) begin : g_slot
		localparam int Slot = i % NUM_CHANNELS;
		assign slot_lut[i] = SW'(Slot);
	end

	assign room = ((OCW + 1)'(out_count) + (OCW + 1)'(rd_vld_s1)) < (OCW + 1)'(OUT_DEPTH);
	assign rd_last_next = (CW'(rd_idx_q) + CW'(1)) == wr_cnt_q;
	assign enq_slot  = slot_lut[cmd.chan];
	assign rd_chan   = rd_data_s1[CHAN_W-1:0];
	assign rd_sender = rd_data_s1[EW-1:CHAN_W];
	assign rd_slot   = slot_lut[rd_chan];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && cmd.kind == CMD_TICK && wr_cnt_q != '0) begin
					state_d = BK_REPLAY;
				end
			end
			BK_REPLAY: begin
				if (room && rd_last_next) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (rd_vld_s1) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		do_enq  = 1'b0;
		do_drop = 1'b0;
		issue   = 1'b0;
		clear   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_ENQ: begin
							cmd_pop = 1'b1;
							do_enq  = 1'b1;
						end
						CMD_DROP: begin
							cmd_pop = room;
							do_drop = room;
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			BK_REPLAY: issue = room;
			BK_FLUSH:  clear = rd_vld_s1;
			default: ;
		endcase
	end

	assign res_push = do_drop | rd_vld_s1;

	always_comb begin
		if (rd_vld_s1) begin
			res.sender = SENDER_W'(rd_sender);
			res.chan   = rd_chan;
			res.status = (use_cnt_q[rd_slot] == 2'd2) ? ST_COLLISION : ST_SUCCESS;
			res.last   = rd_last_s1;
		end else begin
			res.sender = cmd.sender;
			res.chan   = cmd.chan;
			res.status = ST_DROPPED;
			res.last   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_enq) begin
			mem_q[wr_cnt_q[AW-1:0]] <= {cmd.sender[SID_W-1:0], cmd.chan};
		end
		if (issue) begin
			rd_data_s1 <= mem_q[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			wr_cnt_q   <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_vld_s1  <= issue;
			rd_last_s1 <= issue & rd_last_next;
			if (clear) begin
				wr_cnt_q <= '0;
				rd_idx_q <= '0;
			end else begin
				if (do_enq) begin
					wr_cnt_q <= wr_cnt_q + CW'(1);
				end
				if (issue && !rd_last_next) begin
					rd_idx_q <= rd_idx_q + AW'(1);
				end
			end
		end
	end

	for (genvar j = 0; j < NSLOT; j++) begin : g_use
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				use_cnt_q[j] <= 2'd0;
			end else if (clear) begin
				use_cnt_q[j] <= 2'd0;
			end else if (do_enq && enq_slot == SW'(j) && use_cnt_q[j] != 2'd2) begin
				use_cnt_q[j] <= use_cnt_q[j] + 2'd1;
			end
		end
	end

endmodule

[dv/slotted_channel_collision_detect_core_test.sv]
module slotted_channel_collision_detect_core_test;

	localparam int MAX_PEND   = scd_pkg::MAX_PENDING_DEF;
	localparam int NUM_CH     = scd_pkg::NUM_CHANNELS_DEF;
	localparam logic [scd_pkg::SENDER_W-1:0] ID_MASK =
		scd_pkg::SENDER_W'((1 << scd_pkg::ID_BITS_DEF) - 1);
	localparam logic REQ_ACCESS = 1'b0;
	localparam logic REQ_TICK   = 1'b1;
	localparam int ITEM_TARGET  = 420;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 5000;

	logic                          clk;
	logic                          arst_n;
	logic                          push;
	logic                          full;
	logic                          req_type;
	logic [scd_pkg::SENDER_W-1:0]  sender_id;
	logic [scd_pkg::CHAN_W-1:0]    channel;
	logic                          empty;
	logic                          pop;
	logic [scd_pkg::SENDER_W-1:0]  sender_id_out;
	logic [scd_pkg::CHAN_W-1:0]    channel_out;
	logic [1:0]                    status;
	logic                          last;

	int items_sent;
	int burst_left;
	int idle_cycles;

	slotted_channel_collision_detect_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.sender_id     (sender_id),
		.channel       (channel),
		.empty         (empty),
		.pop           (pop),
		.sender_id_out (sender_id_out),
		.channel_out   (channel_out),
		.status        (status),
		.last          (last)
	);

	class slot_replay_tracker;
		logic [scd_pkg::SENDER_W-1:0] queued_sender[$];
		logic [scd_pkg::CHAN_W-1:0]   queued_chan[$];
		logic [1:0]                   chan_uses[NUM_CH];
		scd_pkg::res_t                feedback_due[$];
		int                           errors;

		function new();
			errors = 0;
			clear_period();
		endfunction

		function void clear_period();
			queued_sender.delete();
			queued_chan.delete();
			foreach (chan_uses[i]) chan_uses[i] = 2'd0;
		endfunction

		function void note_item(logic kind, logic [scd_pkg::SENDER_W-1:0] snd,
				logic [scd_pkg::CHAN_W-1:0] ch);
			scd_pkg::res_t r;
			int slot;
			int n;
			snd = snd & ID_MASK;
			if (kind == REQ_ACCESS) begin
				if (queued_sender.size() >= MAX_PEND) begin
					r.sender = snd;
					r.chan   = ch;
					r.status = scd_pkg::ST_DROPPED;
					r.last   = 1'b0;
					feedback_due = {feedback_due, r};
				end else begin
					queued_sender = {queued_sender, snd};
					queued_chan   = {queued_chan, ch};
					slot = ch % NUM_CH;
					if (chan_uses[slot] < 2'd2)
						chan_uses[slot]++;
				end
			end else begin
				n = queued_sender.size();
				for (int i = 0; i < n; i++) begin
					r.sender = queued_sender[i];
					r.chan   = queued_chan[i];
					r.status = (chan_uses[queued_chan[i] % NUM_CH] >= 2'd2) ?
						scd_pkg::ST_COLLISION : scd_pkg::ST_SUCCESS;
					r.last   = (i == n - 1);
					feedback_due = {feedback_due, r};
				end
				clear_period();
			end
		endfunction

		function void check_result(logic [scd_pkg::SENDER_W-1:0] snd,
				logic [scd_pkg::CHAN_W-1:0] ch, logic [1:0] st, logic lst);
			scd_pkg::res_t exp_r;
			if (feedback_due.size() == 0) begin
				$display("%0t: unexpected item sender %0d channel %0d status %0d last %0d",
					$time, snd, ch, st, lst);
				errors++;
				return;
			end
			exp_r = feedback_due.pop_front();
			if (exp_r.sender !== snd) begin
				$display("%0t: sender_id_out expected %0d got %0d", $time, exp_r.sender, snd);
				errors++;
			end
			if (exp_r.chan !== ch) begin
				$display("%0t: channel_out expected %0d got %0d", $time, exp_r.chan, ch);
				errors++;
			end
			if (exp_r.status !== st) begin
				$display("%0t: status expected %0d got %0d", $time, exp_r.status, st);
				errors++;
			end
			if (exp_r.last !== lst) begin
				$display("%0t: last expected %0d got %0d", $time, exp_r.last, lst);
				errors++;
			end
		endfunction
	endclass

	slot_replay_tracker tracker = new();

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input logic kind, input logic [scd_pkg::SENDER_W-1:0] snd,
			input logic [scd_pkg::CHAN_W-1:0] ch);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		push      = 1'b1;
		req_type  = kind;
		sender_id = snd;
		channel   = ch;
		do @(posedge clk); while (full);
		tracker.note_item(kind, snd, ch);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_item(REQ_TICK, scd_pkg::SENDER_W'($urandom_range(0, 255)),
			scd_pkg::CHAN_W'($urandom_range(0, 15)));
	endtask

	// one slot period: n requests then a tick; tight pools make collisions likely
	task automatic send_period(input int n, input bit crowded);
		logic [scd_pkg::CHAN_W-1:0] base;
		base = scd_pkg::CHAN_W'($urandom_range(0, 15));
		for (int i = 0; i < n; i++) begin
			if (crowded)
				send_item(REQ_ACCESS, scd_pkg::SENDER_W'($urandom_range(0, 255)),
					scd_pkg::CHAN_W'(base + $urandom_range(0, 2)));
			else
				send_item(REQ_ACCESS, scd_pkg::SENDER_W'($urandom_range(0, 255)),
					scd_pkg::CHAN_W'($urandom_range(0, 15)));
		end
		send_tick();
	endtask

	initial begin
		int pick;
		int n;
		arst_n     = 1'b0;
		push       = 1'b0;
		req_type   = REQ_ACCESS;
		sender_id  = '0;
		channel    = '0;
		items_sent = 0;
		burst_left = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// tick on an empty queue gives nothing
		send_item(REQ_TICK, 8'd0, 4'd0);
		send_item(REQ_ACCESS, 8'd0, 4'd0);
		send_item(REQ_TICK, 8'd255, 4'd15);
		send_item(REQ_ACCESS, 8'd255, 4'd15);
		send_item(REQ_ACCESS, 8'd170, 4'd5);
		send_item(REQ_ACCESS, 8'd85, 4'd5);
		send_tick();
		// use count saturates at two
		send_item(REQ_ACCESS, 8'd1, 4'd10);
		send_item(REQ_ACCESS, 8'd2, 4'd10);
		send_item(REQ_ACCESS, 8'd3, 4'd10);
		send_item(REQ_ACCESS, 8'd4, 4'd11);
		send_item(REQ_ACCESS, 8'd5, 4'd10);
		send_tick();
		send_tick();

		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				send_tick();
			else begin
				pick = $urandom_range(0, 99);
				if (pick < 65)
					n = $urandom_range(1, 8);
				else if (pick < 85)
					n = $urandom_range(9, 24);
				else
					n = $urandom_range(MAX_PEND - 2, MAX_PEND + 6);
				send_period(n, 1'($urandom_range(0, 1)));
			end
		end
		push = 1'b0;

		while (tracker.feedback_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (tracker.errors == 0 && tracker.feedback_due.size() == 0)
			$display("slotted_channel_collision_detect_core_test: done, clean");
		else
			$display("slotted_channel_collision_detect_core_test: done, errors");
		$finish;
	end

	// receiver: picks among four stall patterns at random, plus one long hold-off
	initial begin
		int mode;
		int cyc;
		bit held;
		pop  = 1'b0;
		mode = 0;
		cyc  = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (!held && items_sent >= 60) begin
				held = 1'b1;
				pop  = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: pop = 1'b1;
				1: pop = ($urandom_range(0, 3) != 0);
				2: pop = ($urandom_range(0, 2) == 0);
				default: pop = cyc[2];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			tracker.check_result(sender_id_out, channel_out, status, last);
	end

	always @(posedge clk) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("slotted_channel_collision_detect_core_test: done, errors");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

[slotted_channel_collision_detect_core.f]
hw/rtl/scd_pkg.sv
hw/rtl/scd_fifo.sv
hw/rtl/scd_front.sv
hw/rtl/scd_back.sv
hw/rtl/slotted_channel_collision_detect_core.sv
dv/slotted_channel_collision_detect_core_test.sv
